// ===== hw/rtl/ctbuf_pkg.sv =====
// Package for the cursor text line buffer: constants, op codes, control types.
`default_nettype none
package ctbuf_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int OP_W         = 3;
    localparam int CHAR_W       = 8;
    localparam int TGT_W        = 8;
    localparam int POS_OUT_W    = 7;

    typedef enum logic [OP_W-1:0] {
        OP_LEFT   = 3'd0,
        OP_RIGHT  = 3'd1,
        OP_INSERT = 3'd2,
        OP_DELETE = 3'd3,
        OP_MOVE   = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_RESP = 2'd2
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
    } t_dp_cmd;

endpackage
`default_nettype wire

// ===== hw/rtl/cursor_text_line_buffer_unit.sv =====
// Top level of the cursor text line buffer: controller, datapath and checks.
// A command is captured on acceptance, executed in the EXEC state and its result is
// held in the RESP state until the output ready takes it; only then does the
// controller return to idle and accept the next command.
// Reset (synchronous, active low): cursor and length go to zero, buffer empty;
// character cells are not cleared and take effect only once written.
`default_nettype none
module cursor_text_line_buffer_unit #(
    parameter int CAPACITY = ctbuf_pkg::CAPACITY_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [ctbuf_pkg::OP_W-1:0]     i_op,
    input  wire logic [ctbuf_pkg::CHAR_W-1:0]   i_char_in,
    input  wire logic [ctbuf_pkg::TGT_W-1:0]    i_target_pos,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [ctbuf_pkg::POS_OUT_W-1:0]     o_cursor_pos,
    output logic [ctbuf_pkg::POS_OUT_W-1:0]     o_text_len,
    output logic                                o_refused
);

    ctbuf_pkg::t_dp_cmd cmd;

    ctbuf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    ctbuf_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_op         (i_op),
        .i_char_in    (i_char_in),
        .i_target_pos (i_target_pos),
        .o_cursor_pos (o_cursor_pos),
        .o_text_len   (o_text_len),
        .o_refused    (o_refused)
    );

    a_cursor_in_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_cursor_pos <= o_text_len))
        else $error("cursor beyond text length");

    a_refused_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_refused) |-> (o_text_len == ctbuf_pkg::POS_OUT_W'(CAPACITY)))
        else $error("refused without full buffer");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("new transaction taken while result pending");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> ##1 o_out_valid)
        else $error("result missing two cycles after transaction");

endmodule
`default_nettype wire

// ===== hw/rtl/ctbuf_ctrl.sv =====
// Controller state machine: sequences capture, execute and respond per command.
`default_nettype none
module ctbuf_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output ctbuf_pkg::t_dp_cmd    o_cmd
);

    ctbuf_pkg::t_state r_state;
    ctbuf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ctbuf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ctbuf_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = ctbuf_pkg::ST_EXEC;
            end
            ctbuf_pkg::ST_EXEC: begin
                n_state = ctbuf_pkg::ST_RESP;
            end
            ctbuf_pkg::ST_RESP: begin
                if (i_out_ready) n_state = ctbuf_pkg::ST_IDLE;
            end
            default: begin
                n_state = ctbuf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        unique case (r_state)
            ctbuf_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ctbuf_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            ctbuf_pkg::ST_RESP: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ctbuf_dp.sv =====
// Datapath: command registers, cursor and length, and the shifting chain of character cells.
`default_nettype none
module ctbuf_dp #(
    parameter int CAPACITY = ctbuf_pkg::CAPACITY_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire ctbuf_pkg::t_dp_cmd             i_cmd,
    input  wire logic [ctbuf_pkg::OP_W-1:0]     i_op,
    input  wire logic [ctbuf_pkg::CHAR_W-1:0]   i_char_in,
    input  wire logic [ctbuf_pkg::TGT_W-1:0]    i_target_pos,
    output logic [ctbuf_pkg::POS_OUT_W-1:0]     o_cursor_pos,
    output logic [ctbuf_pkg::POS_OUT_W-1:0]     o_text_len,
    output logic                                o_refused
);

    localparam int PW = $clog2(CAPACITY + 1);
    localparam int CW = (PW > ctbuf_pkg::TGT_W) ? PW : ctbuf_pkg::TGT_W;

    logic [ctbuf_pkg::OP_W-1:0]   r_op;
    logic [ctbuf_pkg::CHAR_W-1:0] r_ch;
    logic [ctbuf_pkg::TGT_W-1:0]  r_tgt;
    logic [PW-1:0]                r_cursor;
    logic [PW-1:0]                r_len;
    logic                         r_refused;
    logic [PW-1:0]                n_cursor;
    logic [PW-1:0]                n_len;
    logic                         n_refused;
    logic [ctbuf_pkg::CHAR_W-1:0] r_cell [CAPACITY];

    logic full;
    logic do_insert;
    logic do_delete;

    assign full      = (r_len == PW'(CAPACITY));
    assign do_insert = i_cmd.exec && (r_op == ctbuf_pkg::OP_INSERT) && !full;
    assign do_delete = i_cmd.exec && (r_op == ctbuf_pkg::OP_DELETE) && (r_cursor != '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_op;
            r_ch  <= i_char_in;
            r_tgt <= i_target_pos;
        end
    end

    always_comb begin
        n_cursor  = r_cursor;
        n_len     = r_len;
        n_refused = 1'b0;
        unique case (r_op)
            ctbuf_pkg::OP_LEFT: begin
                if (r_cursor != '0) n_cursor = r_cursor - PW'(1);
            end
            ctbuf_pkg::OP_RIGHT: begin
                if (r_cursor < r_len) n_cursor = r_cursor + PW'(1);
            end
            ctbuf_pkg::OP_INSERT: begin
                if (full) begin
                    n_refused = 1'b1;
                end else begin
                    n_cursor = r_cursor + PW'(1);
                    n_len    = r_len + PW'(1);
                end
            end
            ctbuf_pkg::OP_DELETE: begin
                if (r_cursor != '0) begin
                    n_cursor = r_cursor - PW'(1);
                    n_len    = r_len - PW'(1);
                end
            end
            ctbuf_pkg::OP_MOVE: begin
                if (CW'(r_tgt) <= CW'(r_len)) n_cursor = PW'(r_tgt);
            end
            default: begin
                n_refused = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor  <= '0;
            r_len     <= '0;
            r_refused <= 1'b0;
        end else if (i_cmd.exec) begin
            r_cursor  <= n_cursor;
            r_len     <= n_len;
            r_refused <= n_refused;
        end
    end

    // each cell loads the inserted byte, its left neighbor, or its right neighbor
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic from_left;
        logic from_right;
        if (k > 0) begin : g_left
            assign from_left = do_insert && (PW'(k) > r_cursor) && (PW'(k) <= r_len);
        end else begin : g_no_left
            assign from_left = 1'b0;
        end
        if (k < CAPACITY - 1) begin : g_right
            assign from_right = do_delete && (PW'(k + 1) >= r_cursor) &&
                                (PW'(k + 1) < r_len);
        end else begin : g_no_right
            assign from_right = 1'b0;
        end

        always_ff @(posedge i_clk) begin
            if (do_insert && (PW'(k) == r_cursor)) begin
                r_cell[k] <= r_ch;
            end else if (from_left) begin
                r_cell[k] <= r_cell[(k > 0) ? k - 1 : 0];
            end else if (from_right) begin
                r_cell[k] <= r_cell[(k < CAPACITY - 1) ? k + 1 : k];
            end
        end
    end

    assign o_cursor_pos = ctbuf_pkg::POS_OUT_W'(r_cursor);
    assign o_text_len   = ctbuf_pkg::POS_OUT_W'(r_len);
    assign o_refused    = r_refused;

endmodule
`default_nettype wire

// ===== tb/tb_cursor_text_line_buffer_unit.sv =====
// Self-checking testbench for the cursor text line buffer: directed table, then random edits.
`default_nettype none
module tb_cursor_text_line_buffer_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import ctbuf_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam int BLOCK_ITEMS = 78;
    localparam int HOLD_AT = 700;
    localparam int HOLD_CYCLES = 150;
    localparam int DRAIN_LIMIT = 4000;
    localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

    typedef enum int {
        STY_GROW   = 0,
        STY_NAV    = 1,
        STY_SHRINK = 2,
        STY_ANY    = 3
    } t_edit_style;

    typedef struct packed {
        logic [POS_OUT_W-1:0] cursor;
        logic [POS_OUT_W-1:0] len;
        logic                 refused;
    } t_line_status;

    typedef struct {
        logic [OP_W-1:0]      op;
        logic [CHAR_W-1:0]    ch;
        logic [TGT_W-1:0]     tgt;
        bit                   typed;
        logic [POS_OUT_W-1:0] cursor;
        logic [POS_OUT_W-1:0] len;
        logic                 refused;
    } t_edit_row;

    // opening edits; typed rows carry the status that follows at a glance
    t_edit_row script [23] = '{
        '{OP_LEFT,   8'h00, 8'h00, 1'b1, 7'd0, 7'd0, 1'b0},
        '{OP_DELETE, 8'hFF, 8'hFF, 1'b1, 7'd0, 7'd0, 1'b0},
        '{OP_RIGHT,  8'h00, 8'h00, 1'b1, 7'd0, 7'd0, 1'b0},
        '{OP_MOVE,   8'h00, 8'h00, 1'b1, 7'd0, 7'd0, 1'b0},
        '{OP_MOVE,   8'h00, 8'hFF, 1'b1, 7'd0, 7'd0, 1'b0},
        '{OP_RSVD5,  8'hFF, 8'h00, 1'b1, 7'd0, 7'd0, 1'b0},
        '{OP_RSVD6,  8'h00, 8'hFF, 1'b1, 7'd0, 7'd0, 1'b0},
        '{OP_RSVD7,  8'hFF, 8'hFF, 1'b1, 7'd0, 7'd0, 1'b0},
        '{OP_INSERT, 8'h00, 8'h00, 1'b1, 7'd1, 7'd1, 1'b0},
        '{OP_INSERT, 8'hFF, 8'hFF, 1'b1, 7'd2, 7'd2, 1'b0},
        '{OP_INSERT, 8'hA5, 8'h00, 1'b1, 7'd3, 7'd3, 1'b0},
        '{OP_LEFT,   8'h00, 8'h00, 1'b0, 7'd0, 7'd0, 1'b0},
        '{OP_LEFT,   8'h00, 8'h00, 1'b0, 7'd0, 7'd0, 1'b0},
        '{OP_INSERT, 8'h5A, 8'h00, 1'b0, 7'd0, 7'd0, 1'b0},
        '{OP_MOVE,   8'h00, 8'h04, 1'b1, 7'd4, 7'd4, 1'b0},
        '{OP_RIGHT,  8'h00, 8'h00, 1'b1, 7'd4, 7'd4, 1'b0},
        '{OP_MOVE,   8'h00, 8'h05, 1'b1, 7'd4, 7'd4, 1'b0},
        '{OP_MOVE,   8'h00, 8'h00, 1'b1, 7'd0, 7'd4, 1'b0},
        '{OP_DELETE, 8'h00, 8'h00, 1'b1, 7'd0, 7'd4, 1'b0},
        '{OP_RIGHT,  8'h00, 8'h00, 1'b0, 7'd0, 7'd0, 1'b0},
        '{OP_DELETE, 8'h00, 8'h00, 1'b0, 7'd0, 7'd0, 1'b0},
        '{OP_MOVE,   8'h00, 8'h03, 1'b1, 7'd3, 7'd3, 1'b0},
        '{OP_MOVE,   8'h00, 8'h80, 1'b1, 7'd3, 7'd3, 1'b0}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [OP_W-1:0]      i_op;
    logic [CHAR_W-1:0]    i_char_in;
    logic [TGT_W-1:0]     i_target_pos;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [POS_OUT_W-1:0] o_cursor_pos;
    logic [POS_OUT_W-1:0] o_text_len;
    logic                 o_refused;

    // shadow of the line buffer
    logic [CHAR_W-1:0] line_mem [0:CAP-1];
    int cur_idx = 0;
    int txt_len = 0;

    t_line_status pending_status [$];
    bit           row_typed;
    t_line_status row_status;

    int tx_idle_pct;
    int rx_idle_pct;
    int n_cmds = 0;
    int n_results = 0;
    int n_refused = 0;
    int n_full_hits = 0;
    int peak_len = 0;
    int n_errors = 0;
    int hold_left = 0;
    bit hold_done = 0;

    cursor_text_line_buffer_unit #(.CAPACITY(CAP)) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_char_in    (i_char_in),
        .i_target_pos (i_target_pos),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_cursor_pos (o_cursor_pos),
        .o_text_len   (o_text_len),
        .o_refused    (o_refused)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("tb_cursor_text_line_buffer_unit failed");
        $finish;
    end

    task automatic edit_line(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                             input logic [TGT_W-1:0] tgt, output t_line_status st);
        int k;
        st.refused = 1'b0;
        case (op)
            OP_LEFT: begin
                if (cur_idx > 0) cur_idx--;
            end
            OP_RIGHT: begin
                if (cur_idx < txt_len) cur_idx++;
            end
            OP_INSERT: begin
                if (txt_len >= CAP) begin
                    st.refused = 1'b1;
                end else begin
                    for (k = txt_len; k > cur_idx; k--) line_mem[k] = line_mem[k-1];
                    line_mem[cur_idx] = ch;
                    cur_idx++;
                    txt_len++;
                end
            end
            OP_DELETE: begin
                if (cur_idx > 0) begin
                    for (k = cur_idx; k < txt_len; k++) line_mem[k-1] = line_mem[k];
                    cur_idx--;
                    txt_len--;
                end
            end
            OP_MOVE: begin
                if (int'(tgt) <= txt_len) cur_idx = int'(tgt);
            end
            default: ;
        endcase
        st.cursor = cur_idx[POS_OUT_W-1:0];
        st.len = txt_len[POS_OUT_W-1:0];
    endtask

    always @(posedge i_clk) begin
        t_line_status want;
        t_line_status model;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (pending_status.size() == 0) begin
                    $error("result transaction with nothing expected: cursor %0d len %0d",
                           o_cursor_pos, o_text_len);
                    n_errors++;
                end else begin
                    want = pending_status.pop_front();
                    if (o_cursor_pos !== want.cursor) begin
                        $error("cursor_pos: expected %0d, got %0d", want.cursor, o_cursor_pos);
                        n_errors++;
                    end
                    if (o_text_len !== want.len) begin
                        $error("text_len: expected %0d, got %0d", want.len, o_text_len);
                        n_errors++;
                    end
                    if (o_refused !== want.refused) begin
                        $error("refused: expected %0b, got %0b", want.refused, o_refused);
                        n_errors++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                n_cmds++;
                if (i_op == OP_INSERT && txt_len >= CAP) n_full_hits++;
                edit_line(i_op, i_char_in, i_target_pos, model);
                if (model.refused) n_refused++;
                if (txt_len > peak_len) peak_len = txt_len;
                pending_status.push_back(row_typed ? row_status : model);
            end
        end
    end

    // result side: random stalls plus one long hold-off
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_ready = 1'b0;
                hold_left--;
            end else if (!hold_done && n_cmds >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                i_out_ready = 1'b0;
            end else begin
                i_out_ready = ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                            input logic [TGT_W-1:0] tgt);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_op = op;
        i_char_in = ch;
        i_target_pos = tgt;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        i_in_valid = 1'b0;
        while (pending_status.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        @(negedge i_clk);
    endtask

    function automatic logic [OP_W-1:0] pick_op(input t_edit_style sty);
        int r;
        logic [OP_W-1:0] rsvd [3];
        r = $urandom_range(0, 99);
        rsvd = '{OP_RSVD5, OP_RSVD6, OP_RSVD7};
        case (sty)
            STY_GROW: begin
                if (r < 88) return OP_INSERT;
                if (r < 92) return OP_LEFT;
                if (r < 95) return OP_RIGHT;
                if (r < 98) return OP_MOVE;
                return OP_DELETE;
            end
            STY_NAV: begin
                if (r < 25) return OP_LEFT;
                if (r < 50) return OP_RIGHT;
                if (r < 85) return OP_MOVE;
                if (r < 92) return OP_INSERT;
                if (r < 97) return OP_DELETE;
                return rsvd[$urandom_range(0, 2)];
            end
            STY_SHRINK: begin
                if (r < 62) return OP_DELETE;
                if (r < 70) return OP_LEFT;
                if (r < 78) return OP_RIGHT;
                if (r < 90) return OP_MOVE;
                if (r < 96) return OP_INSERT;
                return rsvd[$urandom_range(0, 2)];
            end
            default: return OP_W'($urandom_range(0, 7));
        endcase
    endfunction

    // biased toward the length boundary, with some full-range targets
    function automatic logic [TGT_W-1:0] pick_target();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return TGT_W'($urandom_range(0, txt_len));
        if (r < 55) return TGT_W'(txt_len + 1);
        if (r < 65) return TGT_W'(txt_len);
        if (r < 70) return '0;
        return TGT_W'($urandom_range(0, 255));
    endfunction

    initial begin
        int seg;
        int blk;
        int n;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_op = '0;
        i_char_in = '0;
        i_target_pos = '0;
        row_typed = 1'b0;
        row_status = '0;
        tx_idle_pct = 28;
        rx_idle_pct = 88;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (script[row]) begin
            row_typed = script[row].typed;
            row_status = '{script[row].cursor, script[row].len, script[row].refused};
            send_cmd(script[row].op, script[row].ch, script[row].tgt);
        end
        row_typed = 1'b0;
        drain_results();

        for (seg = 0; seg < 3; seg++) begin
            case (seg)
                0: begin tx_idle_pct = 28; rx_idle_pct = 88; end
                1: begin tx_idle_pct = 88; rx_idle_pct = 28; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            for (blk = 0; blk < 4; blk++) begin
                for (n = 0; n < BLOCK_ITEMS; n++) begin
                    send_cmd(pick_op(t_edit_style'(blk)), CHAR_W'($urandom_range(0, 255)),
                             pick_target());
                end
            end
            // sender holds back until every outstanding result is back or the drain limit runs out
            drain_results();
        end

        repeat (20) @(posedge i_clk);
        if (pending_status.size() != 0) begin
            $error("%0d results never arrived", pending_status.size());
            n_errors++;
        end

        $display("Ran %0d edit commands, checked %0d results, peak line length %0d of %0d.",
                 n_cmds, n_results, peak_len, CAP);
        $display("Inserts into a full line: %0d (predicted refusals %0d), errors: %0d.",
                 n_full_hits, n_refused, n_errors);
        if (n_errors == 0) begin
            $display("tb_cursor_text_line_buffer_unit passed");
        end else begin
            $display("tb_cursor_text_line_buffer_unit failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
